// ----- rtl/bpc_pkg.sv -----
package bpc_pkg;

    localparam int ROWS_PER_PAGE = 8;
    localparam int QDEPTH        = 4;
    localparam int QCW           = $clog2(QDEPTH + 1);
    localparam int PAGE_W        = 6;
    localparam int COL_W         = 10;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 7;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH_BYTES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_PAGE        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_COLUMN      = 3'd3;

    localparam logic [6:0] HEIGHT_RST = 7'd64;
    localparam logic [4:0] WIDTH_RST  = 5'd16;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       image_start;
    } t_in;

    typedef struct packed {
        logic [7:0] column_byte;
        logic [3:0] page_index;
        logic [7:0] column_index;
        logic       out_of_range;
        logic       last_of_run;
        logic       last_of_image;
    } t_out;

    typedef struct packed {
        logic [6:0] image_height;
        logic [4:0] image_width_bytes;
        logic [2:0] start_page;
        logic [6:0] start_column;
    } t_cfg;

    // one transposed 8x8 block waiting to be sent as eight column bytes
    typedef struct packed {
        logic [7:0][7:0]    cols;
        logic [PAGE_W-1:0]  page;
        logic [COL_W-1:0]   col_base;
        logic               last_img;
    } t_run;

endpackage

// ----- rtl/bitmap_to_page_columns_unit.sv -----
// channel | valid       | ready       | payload
// in      | i_in_valid  | o_in_ready  | i_in  (bpc_pkg::t_in)
// out     | o_out_valid | i_out_ready | o_out (bpc_pkg::t_out)
// cfg     | i_cfg_valid | o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item accepted per cycle while the run queue (4 runs of 8) has room.
// An item on a strip's last row yields 8 items from the output register, one per cycle
// while i_out_ready allows; an input item passes the stage-1 reg and the run queue first.
// Synchronous active-low reset clears counters, queue and valids; store is not cleared.
// Output stalls fill the queue, then drop o_in_ready; o_cfg_ready is always high.
module bitmap_to_page_columns_unit #(
    parameter int MAX_WIDTH_BYTES = 16,
    parameter int MAX_HEIGHT      = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  bpc_pkg::t_in                      i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output bpc_pkg::t_out                     o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    bpc_pkg::t_cfg           r_cfg;
    bpc_pkg::t_run           run, head;
    logic                    run_valid, pop;
    logic [bpc_pkg::QCW-1:0] q_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_height      <= bpc_pkg::HEIGHT_RST;
            r_cfg.image_width_bytes <= bpc_pkg::WIDTH_RST;
            r_cfg.start_page        <= '0;
            r_cfg.start_column      <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bpc_pkg::REG_IMAGE_HEIGHT:      r_cfg.image_height      <= i_cfg_data;
                bpc_pkg::REG_IMAGE_WIDTH_BYTES: r_cfg.image_width_bytes <= i_cfg_data[4:0];
                bpc_pkg::REG_START_PAGE:        r_cfg.start_page        <= i_cfg_data[2:0];
                bpc_pkg::REG_START_COLUMN:      r_cfg.start_column      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    bpc_front #(
        .MAX_WIDTH_BYTES (MAX_WIDTH_BYTES),
        .MAX_HEIGHT      (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_q_count   (q_count),
        .o_run_valid (run_valid),
        .o_run       (run)
    );

    bpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (run_valid),
        .i_data  (run),
        .i_pop   (pop),
        .o_head  (head),
        .o_count (q_count)
    );

    bpc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_count != '0),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// ----- rtl/bpc_ram.sv -----
module bpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bpc_front.sv -----
module bpc_front #(
    parameter int MAX_WIDTH_BYTES = 16,
    parameter int MAX_HEIGHT      = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bpc_pkg::t_cfg          i_cfg,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  bpc_pkg::t_in           i_in,
    input  logic [bpc_pkg::QCW-1:0] i_q_count,
    output logic                   o_run_valid,
    output bpc_pkg::t_run          o_run
);

    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int BW = (MAX_WIDTH_BYTES > 1) ? $clog2(MAX_WIDTH_BYTES) : 1;
    localparam int WW = $clog2(MAX_WIDTH_BYTES + 1);

    logic [RW-1:0] r_row, n_row;
    logic [BW-1:0] r_byte, n_byte;
    logic [HW-1:0] h;
    logic [WW-1:0] w;
    logic [RW-1:0] rc;
    logic [BW-1:0] bc;
    logic [2:0]    srow;
    logic          accept, wrap, row_end, byte_end, last_row;
    logic [7:0]    rd [bpc_pkg::ROWS_PER_PAGE];

    logic                          r_s1_valid;
    logic [2:0]                    r_s1_srow;
    logic [7:0]                    r_s1_pix;
    logic [bpc_pkg::PAGE_W-1:0]    r_s1_page;
    logic [bpc_pkg::COL_W-1:0]     r_s1_col;
    logic                          r_s1_last;
    logic [7:0]                    row_byte [bpc_pkg::ROWS_PER_PAGE];

    assign h = (i_cfg.image_height == '0) ? HW'(1) :
               ((32'(i_cfg.image_height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) :
                HW'(i_cfg.image_height));
    assign w = (i_cfg.image_width_bytes == '0) ? WW'(1) :
               ((32'(i_cfg.image_width_bytes) > MAX_WIDTH_BYTES) ? WW'(MAX_WIDTH_BYTES) :
                WW'(i_cfg.image_width_bytes));

    assign o_in_ready = (i_q_count + bpc_pkg::QCW'(r_s1_valid)) < bpc_pkg::QCW'(bpc_pkg::QDEPTH);
    assign accept     = i_in_valid && o_in_ready;

    assign wrap = i_in.image_start || (HW'(r_row) >= h) || (WW'(r_byte) >= w);
    assign rc   = wrap ? '0 : r_row;
    assign bc   = wrap ? '0 : r_byte;
    assign srow = rc[2:0];

    assign row_end  = (HW'(rc) == h - HW'(1));
    assign byte_end = (WW'(bc) == w - WW'(1));
    assign last_row = (srow == 3'(bpc_pkg::ROWS_PER_PAGE - 1)) || row_end;

    always_comb begin
        n_row  = r_row;
        n_byte = r_byte;
        if (accept) begin
            if (byte_end) begin
                n_byte = '0;
                n_row  = row_end ? '0 : rc + RW'(1);
            end else begin
                n_byte = bc + BW'(1);
                n_row  = rc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_byte     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_row      <= n_row;
            r_byte     <= n_byte;
            r_s1_valid <= accept && last_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_srow <= srow;
            r_s1_pix  <= i_in.pixel_byte;
            r_s1_page <= bpc_pkg::PAGE_W'(i_cfg.start_page) + bpc_pkg::PAGE_W'(rc >> 3);
            r_s1_col  <= bpc_pkg::COL_W'(i_cfg.start_column) + bpc_pkg::COL_W'({bc, 3'b000});
            r_s1_last <= row_end && byte_end;
        end
    end

    for (genvar g = 0; g < bpc_pkg::ROWS_PER_PAGE; g++) begin : g_row
        bpc_ram #(
            .WIDTH (8),
            .DEPTH (MAX_WIDTH_BYTES)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (accept && (srow == 3'(g))),
            .i_waddr (bc),
            .i_wdata (i_in.pixel_byte),
            .i_re    (accept),
            .i_raddr (bc),
            .o_rdata (rd[g])
        );
    end

    // rows above the current one come from the store, rows below are blank
    always_comb begin
        for (int r = 0; r < bpc_pkg::ROWS_PER_PAGE; r++) begin
            if (3'(r) < r_s1_srow) begin
                row_byte[r] = rd[r];
            end else if (3'(r) == r_s1_srow) begin
                row_byte[r] = r_s1_pix;
            end else begin
                row_byte[r] = '0;
            end
        end
        for (int k = 0; k < 8; k++) begin
            for (int r = 0; r < 8; r++) begin
                o_run.cols[k][r] = row_byte[r][7-k];
            end
        end
        o_run.page     = r_s1_page;
        o_run.col_base = r_s1_col;
        o_run.last_img = r_s1_last;
    end

    assign o_run_valid = r_s1_valid;

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_q_count == bpc_pkg::QCW'(bpc_pkg::QDEPTH)) |-> !o_in_ready)
        else $error("item taken with queue full");

endmodule

// ----- rtl/bpc_queue.sv -----
module bpc_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  bpc_pkg::t_run           i_data,
    input  logic                    i_pop,
    output bpc_pkg::t_run           o_head,
    output logic [bpc_pkg::QCW-1:0] o_count
);

    localparam int PW = $clog2(bpc_pkg::QDEPTH);

    bpc_pkg::t_run           r_mem [bpc_pkg::QDEPTH];
    logic [PW-1:0]           r_wptr, r_rptr;
    logic [bpc_pkg::QCW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(bpc_pkg::QDEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(bpc_pkg::QDEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            r_count <= r_count + bpc_pkg::QCW'(i_push) - bpc_pkg::QCW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_head  = r_mem[r_rptr];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != bpc_pkg::QCW'(bpc_pkg::QDEPTH)) || i_pop)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue underflow");

endmodule

// ----- rtl/bpc_back.sv -----
module bpc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  bpc_pkg::t_run i_head,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output bpc_pkg::t_out o_out
);

    logic [2:0]                r_k;
    logic                      r_out_valid;
    bpc_pkg::t_out             r_out;
    logic                      load;
    logic [bpc_pkg::COL_W-1:0] col;
    logic                      last_k;

    assign load   = i_q_valid && (!r_out_valid || i_out_ready);
    assign last_k = (r_k == 3'd7);
    assign o_pop  = load && last_k;
    assign col    = i_head.col_base + bpc_pkg::COL_W'(r_k);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_k <= r_k + 3'd1;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.column_byte   <= i_head.cols[r_k];
            r_out.page_index    <= i_head.page[3:0];
            r_out.column_index  <= col[7:0];
            r_out.out_of_range  <= (i_head.page > bpc_pkg::PAGE_W'(7)) ||
                                   (col > bpc_pkg::COL_W'(127));
            r_out.last_of_run   <= last_k;
            r_out.last_of_image <= last_k && i_head.last_img;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_mid_run_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_k != '0) |-> i_q_valid)
        else $error("run in progress without queue entry");

    a_image_end_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last_of_image) |-> r_out.last_of_run)
        else $error("image end off a run boundary");

endmodule
